[sv/cau_pkg.sv]
package cau_pkg;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_SCALE = 3'd3;
  localparam logic [2:0] OP_DIV   = 3'd4;
  localparam logic [2:0] OP_BCAST = 3'd5;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic valid;
    logic is_div;
    logic dz;
    logic ovf;
    logic neg_re;
    logic neg_im;
    logic pre_ovf_re;
    logic pre_ovf_im;
  } cau_ctl_t;

endpackage

[sv/cau_in_if.sv]
interface cau_in_if #(parameter int WORD_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   operation;
  logic signed [WORD_WIDTH-1:0] a_re;
  logic signed [WORD_WIDTH-1:0] a_im;
  logic signed [WORD_WIDTH-1:0] b_re;
  logic signed [WORD_WIDTH-1:0] b_im;

  modport source (output valid, operation, a_re, a_im, b_re, b_im, input ready);
  modport sink (input valid, operation, a_re, a_im, b_re, b_im, output ready);
endinterface

[sv/cau_out_if.sv]
interface cau_out_if #(parameter int WORD_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] res_re;
  logic signed [WORD_WIDTH-1:0] res_im;
  logic [1:0]                   status;

  modport source (output valid, res_re, res_im, status, input ready);
  modport sink (input valid, res_re, res_im, status, output ready);
endinterface

[sv/cau_front.sv]
module cau_front
  import cau_pkg::*;
#(
  parameter int WORD_WIDTH    = 32,
  parameter int FRACTION_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [2:0]                   in_operation,
  input  logic signed [WORD_WIDTH-1:0] in_a_re,
  input  logic signed [WORD_WIDTH-1:0] in_a_im,
  input  logic signed [WORD_WIDTH-1:0] in_b_re,
  input  logic signed [WORD_WIDTH-1:0] in_b_im,
  output cau_ctl_t                     ctl,
  output logic [WORD_WIDTH-1:0]        carry_re,
  output logic [WORD_WIDTH-1:0]        carry_im,
  output logic [2*WORD_WIDTH-1:0]      rem_re,
  output logic [2*WORD_WIDTH-1:0]      rem_im,
  output logic [WORD_WIDTH-1:0]        ql_re,
  output logic [WORD_WIDTH-1:0]        ql_im,
  output logic [2*WORD_WIDTH-1:0]      den
);

  localparam int W  = WORD_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int XW = 2*W + 1;
  localparam int NW = 2*W + F;
  localparam int CW = (W + F > 2*W) ? W + F : 2*W;
  localparam logic signed [XW-1:0] MAXV = {{(W+2){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] MINV = {{(W+2){1'b1}}, {(W-1){1'b0}}};

  function automatic logic signed [XW-1:0] sx(input logic signed [W-1:0] v);
    return {{(W+1){v[W-1]}}, v};
  endfunction

  function automatic logic [W:0] sat(input logic signed [XW-1:0] v);
    logic [W:0] r;
    if (v > MAXV) begin
      r = {1'b1, MAXV[W-1:0]};
    end else if (v < MINV) begin
      r = {1'b1, MINV[W-1:0]};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  logic                 v1_r, v2_r, v3_r, v4_r;
  logic [2:0]           op1_r, op2_r, op3_r;
  logic signed [W-1:0]  ar1_r, ai1_r, br1_r, bi1_r;

  logic signed [2*W-1:0] prr_r, pii_r, pri_r, pir_r, pbb_r, pcc_r;
  logic signed [XW-1:0]  lre2_r, lim2_r;

  logic signed [XW-1:0]  cre3_r, cim3_r, nre3_r, nim3_r;
  logic [2*W-1:0]        den3_r;

  cau_ctl_t        ctl4_r;
  logic [W-1:0]    cre4_r, cim4_r, qre4_r, qim4_r;
  logic [2*W-1:0]  rre4_r, rim4_r, den4_r;

  logic signed [XW-1:0] lre2_nxt, lim2_nxt, cre3_nxt, cim3_nxt;
  logic signed [XW-1:0] mre_full, mim_full, mag_re_x, mag_im_x;
  logic [NW-1:0]        n_re, n_im;
  logic [CW-1:0]        hi_re, hi_im, den_x;
  logic [W:0]           sre, sim;
  cau_ctl_t             ctl4_nxt;

  always_comb begin
    lre2_nxt = '0;
    lim2_nxt = '0;
    case (op1_r)
      OP_ADD: begin
        lre2_nxt = sx(ar1_r) + sx(br1_r);
        lim2_nxt = sx(ai1_r) + sx(bi1_r);
      end
      OP_SUB: begin
        lre2_nxt = sx(ar1_r) - sx(br1_r);
        lim2_nxt = sx(ai1_r) - sx(bi1_r);
      end
      OP_BCAST: begin
        lre2_nxt = sx(ar1_r);
        lim2_nxt = sx(ar1_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    mre_full = (XW'(prr_r) - XW'(pii_r)) >>> F;
    mim_full = (XW'(pri_r) + XW'(pir_r)) >>> F;
    case (op2_r)
      OP_MUL: begin
        cre3_nxt = mre_full;
        cim3_nxt = mim_full;
      end
      OP_SCALE: begin
        cre3_nxt = XW'(prr_r) >>> F;
        cim3_nxt = XW'(pii_r) >>> F;
      end
      default: begin
        cre3_nxt = lre2_r;
        cim3_nxt = lim2_r;
      end
    endcase
  end

  always_comb begin
    sre = sat(cre3_r);
    sim = sat(cim3_r);
    mag_re_x = nre3_r[XW-1] ? -nre3_r : nre3_r;
    mag_im_x = nim3_r[XW-1] ? -nim3_r : nim3_r;
    n_re = {mag_re_x[2*W-1:0], {F{1'b0}}};
    n_im = {mag_im_x[2*W-1:0], {F{1'b0}}};
    hi_re = CW'(n_re[NW-1:W]);
    hi_im = CW'(n_im[NW-1:W]);
    den_x = CW'(den3_r);
    ctl4_nxt.valid      = v3_r;
    ctl4_nxt.is_div     = (op3_r == OP_DIV);
    ctl4_nxt.dz         = (den3_r == '0);
    ctl4_nxt.ovf        = sre[W] | sim[W];
    ctl4_nxt.neg_re     = nre3_r[XW-1];
    ctl4_nxt.neg_im     = nim3_r[XW-1];
    ctl4_nxt.pre_ovf_re = (hi_re >= den_x);
    ctl4_nxt.pre_ovf_im = (hi_im >= den_x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      ctl4_r <= '0;
    end else if (en) begin
      v1_r   <= in_valid;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      v4_r   <= v3_r;
      ctl4_r <= ctl4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r  <= in_operation;
      ar1_r  <= in_a_re;
      ai1_r  <= in_a_im;
      br1_r  <= in_b_re;
      bi1_r  <= in_b_im;

      op2_r  <= op1_r;
      prr_r  <= ar1_r * br1_r;
      pii_r  <= ai1_r * bi1_r;
      pri_r  <= ar1_r * bi1_r;
      pir_r  <= ai1_r * br1_r;
      pbb_r  <= br1_r * br1_r;
      pcc_r  <= bi1_r * bi1_r;
      lre2_r <= lre2_nxt;
      lim2_r <= lim2_nxt;

      op3_r  <= op2_r;
      cre3_r <= cre3_nxt;
      cim3_r <= cim3_nxt;
      nre3_r <= XW'(prr_r) + XW'(pii_r);
      nim3_r <= XW'(pir_r) - XW'(pri_r);
      den3_r <= pbb_r + pcc_r;

      cre4_r <= sre[W-1:0];
      cim4_r <= sim[W-1:0];
      rre4_r <= hi_re[2*W-1:0];
      rim4_r <= hi_im[2*W-1:0];
      qre4_r <= n_re[W-1:0];
      qim4_r <= n_im[W-1:0];
      den4_r <= den3_r;
    end
  end

  always_comb begin
    ctl       = ctl4_r;
    ctl.valid = v4_r;
  end

  assign carry_re = cre4_r;
  assign carry_im = cim4_r;
  assign rem_re   = rre4_r;
  assign rem_im   = rim4_r;
  assign ql_re    = qre4_r;
  assign ql_im    = qim4_r;
  assign den      = den4_r;

endmodule

[sv/cau_div.sv]
module cau_div
  import cau_pkg::*;
#(
  parameter int WORD_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  cau_ctl_t                ctl_in,
  input  logic [WORD_WIDTH-1:0]   carry_re_in,
  input  logic [WORD_WIDTH-1:0]   carry_im_in,
  input  logic [2*WORD_WIDTH-1:0] rem_re_in,
  input  logic [2*WORD_WIDTH-1:0] rem_im_in,
  input  logic [WORD_WIDTH-1:0]   ql_re_in,
  input  logic [WORD_WIDTH-1:0]   ql_im_in,
  input  logic [2*WORD_WIDTH-1:0] den_in,
  output cau_ctl_t                ctl_out,
  output logic [WORD_WIDTH-1:0]   carry_re_out,
  output logic [WORD_WIDTH-1:0]   carry_im_out,
  output logic [WORD_WIDTH-1:0]   q_re_out,
  output logic [WORD_WIDTH-1:0]   q_im_out
);

  localparam int W = WORD_WIDTH;

  function automatic logic [3*W-1:0] step(input logic [2*W-1:0] rem,
                                          input logic [W-1:0] ql,
                                          input logic [2*W-1:0] d);
    logic [2*W:0] t;
    logic [2*W:0] rn;
    logic         ge;
    t  = {rem, ql[W-1]};
    ge = (t >= {1'b0, d});
    rn = ge ? t - {1'b0, d} : t;
    return {rn[2*W-1:0], ql[W-2:0], ge};
  endfunction

  cau_ctl_t       ctl_r  [W];
  logic [W-1:0]   cre_r  [W];
  logic [W-1:0]   cim_r  [W];
  logic [2*W-1:0] rre_r  [W];
  logic [2*W-1:0] rim_r  [W];
  logic [W-1:0]   qre_r  [W];
  logic [W-1:0]   qim_r  [W];
  logic [2*W-1:0] den_r  [W];

  for (genvar s = 0; s < W; s++) begin : g_stage
    cau_ctl_t       c_i;
    logic [W-1:0]   cre_i, cim_i, qre_i, qim_i;
    logic [2*W-1:0] rre_i, rim_i, den_i;
    logic [3*W-1:0] st_re, st_im;

    if (s == 0) begin : g_first
      assign c_i   = ctl_in;
      assign cre_i = carry_re_in;
      assign cim_i = carry_im_in;
      assign rre_i = rem_re_in;
      assign rim_i = rem_im_in;
      assign qre_i = ql_re_in;
      assign qim_i = ql_im_in;
      assign den_i = den_in;
    end else begin : g_next
      assign c_i   = ctl_r[s-1];
      assign cre_i = cre_r[s-1];
      assign cim_i = cim_r[s-1];
      assign rre_i = rre_r[s-1];
      assign rim_i = rim_r[s-1];
      assign qre_i = qre_r[s-1];
      assign qim_i = qim_r[s-1];
      assign den_i = den_r[s-1];
    end

    assign st_re = step(rre_i, qre_i, den_i);
    assign st_im = step(rim_i, qim_i, den_i);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s] <= '0;
      end else if (en) begin
        ctl_r[s] <= c_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cre_r[s] <= cre_i;
        cim_r[s] <= cim_i;
        rre_r[s] <= st_re[3*W-1:W];
        rim_r[s] <= st_im[3*W-1:W];
        qre_r[s] <= st_re[W-1:0];
        qim_r[s] <= st_im[W-1:0];
        den_r[s] <= den_i;
      end
    end
  end

  assign ctl_out      = ctl_r[W-1];
  assign carry_re_out = cre_r[W-1];
  assign carry_im_out = cim_r[W-1];
  assign q_re_out     = qre_r[W-1];
  assign q_im_out     = qim_r[W-1];

endmodule

[sv/complex_arithmetic_unit.sv]
// Each accepted item passes through cau_front, then cau_div, then the output register.
// Throughput: one item per cycle while the output is not stalled; the division runs one quotient bit per stage,
// so the divider stages (WORD_WIDTH of them) set the depth.
// The whole pipeline advances whenever the output register is empty or being taken.
// Reset (rst_n low, synchronous) clears every valid bit; data registers keep their contents.
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int WORD_WIDTH    = 32,
  parameter int FRACTION_BITS = 24
) (
  input  logic     clk,
  input  logic     rst_n,
  cau_in_if.sink   in_chan,
  cau_out_if.source out_chan
);

  localparam int W = WORD_WIDTH;

  logic           en;
  cau_ctl_t       f_ctl, d_ctl;
  logic [W-1:0]   f_cre, f_cim, f_qre, f_qim;
  logic [2*W-1:0] f_rre, f_rim, f_den;
  logic [W-1:0]   d_cre, d_cim, d_qre, d_qim;

  logic                out_valid_r;
  logic signed [W-1:0] res_re_r, res_im_r, res_re_nxt, res_im_nxt;
  logic [1:0]          status_r, status_nxt;
  logic                ovf_re, ovf_im;

  localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  cau_front #(.WORD_WIDTH(W), .FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_chan.valid),
    .in_operation (in_chan.operation),
    .in_a_re      (in_chan.a_re),
    .in_a_im      (in_chan.a_im),
    .in_b_re      (in_chan.b_re),
    .in_b_im      (in_chan.b_im),
    .ctl          (f_ctl),
    .carry_re     (f_cre),
    .carry_im     (f_cim),
    .rem_re       (f_rre),
    .rem_im       (f_rim),
    .ql_re        (f_qre),
    .ql_im        (f_qim),
    .den          (f_den)
  );

  cau_div #(.WORD_WIDTH(W)) u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .ctl_in       (f_ctl),
    .carry_re_in  (f_cre),
    .carry_im_in  (f_cim),
    .rem_re_in    (f_rre),
    .rem_im_in    (f_rim),
    .ql_re_in     (f_qre),
    .ql_im_in     (f_qim),
    .den_in       (f_den),
    .ctl_out      (d_ctl),
    .carry_re_out (d_cre),
    .carry_im_out (d_cim),
    .q_re_out     (d_qre),
    .q_im_out     (d_qim)
  );

  always_comb begin
    ovf_re = 1'b0;
    ovf_im = 1'b0;
    if (!d_ctl.is_div) begin
      res_re_nxt = d_cre;
      res_im_nxt = d_cim;
      status_nxt = d_ctl.ovf ? ST_OVF : ST_OK;
    end else if (d_ctl.dz) begin
      res_re_nxt = '0;
      res_im_nxt = '0;
      status_nxt = ST_DZ;
    end else begin
      if (d_ctl.neg_re) begin
        ovf_re     = d_ctl.pre_ovf_re || (d_qre > MINW);
        res_re_nxt = ovf_re ? MINW : -d_qre;
      end else begin
        ovf_re     = d_ctl.pre_ovf_re || d_qre[W-1];
        res_re_nxt = ovf_re ? MAXW : d_qre;
      end
      if (d_ctl.neg_im) begin
        ovf_im     = d_ctl.pre_ovf_im || (d_qim > MINW);
        res_im_nxt = ovf_im ? MINW : -d_qim;
      end else begin
        ovf_im     = d_ctl.pre_ovf_im || d_qim[W-1];
        res_im_nxt = ovf_im ? MAXW : d_qim;
      end
      status_nxt = (ovf_re || ovf_im) ? ST_OVF : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.res_re = res_re_r;
  assign out_chan.res_im = res_im_r;
  assign out_chan.status = status_r;

endmodule

[dv/complex_arithmetic_unit_test.sv]
`timescale 1ns / 1ps
module complex_arithmetic_unit_test;
  import cau_pkg::*;

  localparam int WW = 32;
  localparam int FB = 24;
  localparam int LATENCY = WW + 5;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]           operation;
    logic signed [WW-1:0] a_re;
    logic signed [WW-1:0] a_im;
    logic signed [WW-1:0] b_re;
    logic signed [WW-1:0] b_im;
  } operands_t;

  typedef struct packed {
    logic signed [WW-1:0] res_re;
    logic signed [WW-1:0] res_im;
    logic [1:0]           status;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cau_in_if #(.WORD_WIDTH(WW)) in_chan ();
  cau_out_if #(.WORD_WIDTH(WW)) out_chan ();

  complex_arithmetic_unit #(.WORD_WIDTH(WW), .FRACTION_BITS(FB)) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan.sink),
    .out_chan(out_chan.source)
  );

  result_t expected_results[$];
  int      error_count = 0;
  int      results_seen = 0;
  int      items_sent = 0;
  longint  cycle_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  bit      hold_off = 1'b0;
  int      ops_seen[8];

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic signed [WW-1:0] saturate(input logic signed [255:0] v,
                                                    inout bit ovf);
    logic signed [255:0] hi;
    logic signed [255:0] lo;
    hi = (256'sd1 <<< (WW - 1)) - 1;
    lo = -(256'sd1 <<< (WW - 1));
    if (v > hi) begin
      ovf = 1'b1;
      return hi[WW-1:0];
    end
    if (v < lo) begin
      ovf = 1'b1;
      return lo[WW-1:0];
    end
    return v[WW-1:0];
  endfunction

  function automatic logic signed [255:0] div_trunc(input logic signed [255:0] n,
                                                    input logic signed [255:0] d);
    logic signed [255:0] q;
    q = (n < 0) ? -((-n) / d) : n / d;
    return q;
  endfunction

  function automatic result_t predict_complex(input operands_t x);
    result_t r;
    logic signed [255:0] ar, ai, br, bi, re, im, den;
    bit ovf;
    ar = $signed(x.a_re);
    ai = $signed(x.a_im);
    br = $signed(x.b_re);
    bi = $signed(x.b_im);
    re = 0;
    im = 0;
    ovf = 1'b0;
    r.status = ST_OK;
    case (x.operation)
      OP_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      OP_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      OP_MUL: begin
        re = (ar * br - ai * bi) >>> FB;
        im = (ar * bi + ai * br) >>> FB;
      end
      OP_SCALE: begin
        re = (ar * br) >>> FB;
        im = (ai * bi) >>> FB;
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.status = ST_DZ;
        end else begin
          re = div_trunc((ar * br + ai * bi) <<< FB, den);
          im = div_trunc((ai * br - ar * bi) <<< FB, den);
        end
      end
      OP_BCAST: begin
        re = ar;
        im = ar;
      end
      default: begin
      end
    endcase
    r.res_re = saturate(re, ovf);
    r.res_im = saturate(im, ovf);
    if (ovf && r.status == ST_OK) r.status = ST_OVF;
    return r;
  endfunction

  initial begin
    in_chan.valid = 1'b0;
    in_chan.operation = '0;
    in_chan.a_re = '0;
    in_chan.a_im = '0;
    in_chan.b_re = '0;
    in_chan.b_im = '0;
    out_chan.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n || hold_off) out_chan.ready <= 1'b0;
    else out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("Result item with no expectation: re %0h im %0h status %0d",
               out_chan.res_re, out_chan.res_im, out_chan.status);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_chan.res_re !== exp_r.res_re) begin
          $error("res_re: expected %0h, actual %0h", exp_r.res_re, out_chan.res_re);
          error_count++;
        end
        if (out_chan.res_im !== exp_r.res_im) begin
          $error("res_im: expected %0h, actual %0h", exp_r.res_im, out_chan.res_im);
          error_count++;
        end
        if (out_chan.status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, out_chan.status);
          error_count++;
        end
      end
    end
  end

  task automatic send_operands(input operands_t x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.operation <= x.operation;
    in_chan.a_re <= x.a_re;
    in_chan.a_im <= x.a_im;
    in_chan.b_re <= x.b_re;
    in_chan.b_im <= x.b_im;
    do @(posedge clk); while (!in_chan.ready);
    expected_results.push_back(predict_complex(x));
    ops_seen[x.operation]++;
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [WW-1:0] random_word();
    case ($urandom_range(5))
      0: return {1'b0, {(WW-1){1'b1}}};
      1: return {1'b1, {(WW-1){1'b0}}};
      2: return WW'($signed($urandom_range(512)) - 256) <<< ($urandom_range(FB));
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic operands_t random_operands();
    operands_t x;
    x.operation = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                            : 3'($urandom_range(5));
    x.a_re = random_word();
    x.a_im = random_word();
    x.b_re = random_word();
    x.b_im = random_word();
    if (x.operation == OP_DIV && $urandom_range(9) == 0) begin
      x.b_re = '0;
      x.b_im = '0;
    end
    return x;
  endfunction

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    logic signed [WW-1:0] mx, mn, one;
    mx = {1'b0, {(WW-1){1'b1}}};
    mn = {1'b1, {(WW-1){1'b0}}};
    one = 1 <<< FB;
    send_operands('{OP_ADD, mx, mn, one, -one});
    send_operands('{OP_ADD, mn, mn, -one, mn});
    send_operands('{OP_SUB, mn, mx, one, mn});
    send_operands('{OP_SUB, 3, -5, 7, 11});
    send_operands('{OP_MUL, one, one, one, -one});
    send_operands('{OP_MUL, mx, mn, mx, mn});
    send_operands('{OP_MUL, -1, -1, 1, 1});
    send_operands('{OP_SCALE, mn, mn, mn, mx});
    send_operands('{OP_SCALE, -3, 5, one >>> 1, -one});
    send_operands('{OP_DIV, one, one, 0, 0});
    send_operands('{OP_DIV, mx, mn, 0, 0});
    send_operands('{OP_DIV, one, -one, one, one});
    send_operands('{OP_DIV, -one, 7, 3, -1});
    send_operands('{OP_DIV, mx, mx, 1, 0});
    send_operands('{OP_DIV, mn, 0, 0, 1});
    send_operands('{OP_BCAST, mn, mx, mx, mx});
    send_operands('{OP_BCAST, mx, 0, 0, 0});
    send_operands('{3'd6, mx, mx, mx, mx});
    send_operands('{3'd7, mn, mn, mn, mn});
    drain();
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int n);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_operands(random_operands());
    drain();
  endtask

  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (3 * LATENCY) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (LATENCY + 40) send_operands(random_operands());
    join
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_phase(0, 0, 120);
    test_random_phase(52, 0, 110);
    test_random_phase(0, 52, 110);
    test_random_phase(14, 14, 110);
    test_back_pressure();
    $display("Sent %0d items and checked %0d results over %0d cycles.",
             items_sent, results_seen, cycle_count);
    $display("Items per code: %0d %0d %0d %0d %0d %0d %0d %0d", ops_seen[0], ops_seen[1],
             ops_seen[2], ops_seen[3], ops_seen[4], ops_seen[5], ops_seen[6], ops_seen[7]);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[complex_arithmetic_unit.f]
sv/cau_pkg.sv
sv/cau_in_if.sv
sv/cau_out_if.sv
sv/cau_front.sv
sv/cau_div.sv
sv/complex_arithmetic_unit.sv
dv/complex_arithmetic_unit_test.sv
